// ===== design/qrs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_pkg
// Types and constants shared by the quadratic root solver modules.
// ----------------------------------------------------------------------------
package qrs_pkg;

   localparam int COEF_W      = 16;                 // Q8.8 coefficients
   localparam int PROD_W      = 2 * COEF_W;         // a*c, b*b
   localparam int DISC_W      = PROD_W + 3;         // b*b - 4ac, signed
   localparam int MAG_W       = PROD_W + 2;         // |disc|, kept even
   localparam int ROOT_W      = MAG_W / 2;          // isqrt(|disc|)
   localparam int SQRT_STEPS  = ROOT_W;
   localparam int SQ_REM_W    = ROOT_W + 3;
   localparam int NUM_W       = ROOT_W;             // |-b +/- s|
   localparam int NSUM_W      = NUM_W + 2;          // signed numerator
   localparam int DEN_W       = COEF_W + 1;         // |2a|
   localparam int OUT_W       = 32;
   localparam int OUT_FRAC    = 16;
   localparam int QUO_W       = NUM_W + OUT_FRAC;   // unsaturated quotient
   localparam int DIV_STEPS   = QUO_W;
   localparam int DREM_W      = DEN_W + 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      KIND_DISTINCT = 2'd0,
      KIND_EQUAL    = 2'd1,
      KIND_COMPLEX  = 2'd2,
      KIND_A_ZERO   = 2'd3
   } root_kind_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef_a;
      logic signed [COEF_W-1:0] coef_b;
      logic signed [COEF_W-1:0] coef_c;
   } req_type;

   typedef struct packed {
      root_kind_type           root_kind;
      logic signed [OUT_W-1:0] first_value;
      logic signed [OUT_W-1:0] second_value;
   } rsp_type;

   // classified transaction, front to back
   typedef struct packed {
      root_kind_type            kind;
      logic [MAG_W-1:0]         disc_mag;
      logic signed [COEF_W-1:0] coef_a;
      logic signed [COEF_W-1:0] coef_b;
   } class_type;

   // square root result with the coefficients it needs downstream
   typedef struct packed {
      root_kind_type            kind;
      logic [ROOT_W-1:0]        root;
      logic signed [COEF_W-1:0] coef_a;
      logic signed [COEF_W-1:0] coef_b;
   } root_type;

endpackage : qrs_pkg
`default_nettype wire

// ===== design/qrs_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_front
// Forms b*b and a*c, then the exact discriminant and the root kind.
// ----------------------------------------------------------------------------
module qrs_front import qrs_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      enable,
   input  wire logic      in_valid,
   input  wire req_type   in_item,
   output logic           out_valid,
   output class_type      out_item
);

   logic                     s1_vld_ff, s1_vld_in;
   logic signed [PROD_W-1:0] bb_ff, bb_in, ac_ff, ac_in;
   logic signed [COEF_W-1:0] a1_ff, b1_ff;
   logic                     s2_vld_ff;
   class_type                cls_ff, cls_in;
   logic signed [DISC_W-1:0] disc;

   always_comb begin
      s1_vld_in = in_valid;
      bb_in = PROD_W'(in_item.coef_b) * PROD_W'(in_item.coef_b);
      ac_in = PROD_W'(in_item.coef_a) * PROD_W'(in_item.coef_c);
      disc  = DISC_W'(bb_ff) - (DISC_W'(ac_ff) <<< 2);
      cls_in.coef_a   = a1_ff;
      cls_in.coef_b   = b1_ff;
      cls_in.disc_mag = disc[DISC_W-1] ? MAG_W'(-disc) : MAG_W'(disc);
      priority if (a1_ff == '0) begin
         cls_in.kind = KIND_A_ZERO;
      end else if (disc[DISC_W-1]) begin
         cls_in.kind = KIND_COMPLEX;
      end else if (disc == '0) begin
         cls_in.kind = KIND_EQUAL;
      end else begin
         cls_in.kind = KIND_DISTINCT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else if (enable) begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         bb_ff  <= bb_in;
         ac_ff  <= ac_in;
         a1_ff  <= in_item.coef_a;
         b1_ff  <= in_item.coef_b;
         cls_ff <= cls_in;
      end
   end

   assign out_valid = s2_vld_ff;
   assign out_item  = cls_ff;

endmodule : qrs_front
`default_nettype wire

// ===== design/qrs_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_queue
// Short FIFO decoupling the classifier from the root pipeline.
// ----------------------------------------------------------------------------
module qrs_queue import qrs_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire class_type push_item,
   input  wire logic      pop,
   output logic           empty,
   output logic           full,
   output class_type      head
);

   class_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   always_comb begin
      empty     = (count_ff == '0);
      full      = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
      do_pop    = pop && !empty;
      do_push   = push && (!full || do_pop);
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
      head      = mem_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_item;
   end

endmodule : qrs_queue
`default_nettype wire

// ===== design/qrs_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt import qrs_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      enable,
   input  wire logic      in_valid,
   input  wire class_type in_item,
   output logic           out_valid,
   output root_type       out_item
);

   typedef struct packed {
      root_kind_type            kind;
      logic signed [COEF_W-1:0] coef_a;
      logic signed [COEF_W-1:0] coef_b;
      logic [MAG_W-1:0]         x;
      logic [SQ_REM_W-1:0]      rem;
      logic [ROOT_W-1:0]        root;
   } sq_state_type;

   sq_state_type          st_ff [SQRT_STEPS+1];
   sq_state_type          st_in [SQRT_STEPS+1];
   logic [SQRT_STEPS:0]   vld_ff, vld_in;

   function automatic sq_state_type sq_step(input sq_state_type s);
      logic [SQ_REM_W-1:0] r2;
      logic [SQ_REM_W-1:0] trial;
      sq_state_type        o;
      o     = s;
      r2    = {s.rem[SQ_REM_W-3:0], s.x[MAG_W-1 -: 2]};
      trial = {1'b0, s.root, 2'b01};
      o.x   = {s.x[MAG_W-3:0], 2'b00};
      if (r2 >= trial) begin
         o.rem  = r2 - trial;
         o.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
         o.rem  = r2;
         o.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return o;
   endfunction

   always_comb begin
      st_in[0].kind   = in_item.kind;
      st_in[0].coef_a = in_item.coef_a;
      st_in[0].coef_b = in_item.coef_b;
      st_in[0].x      = in_item.disc_mag;
      st_in[0].rem    = '0;
      st_in[0].root   = '0;
      vld_in[0]       = in_valid;
      for (int k = 0; k < SQRT_STEPS; k++) begin
         st_in[k+1]  = sq_step(st_ff[k]);
         vld_in[k+1] = vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) st_ff <= st_in;
   end

   assign out_valid       = vld_ff[SQRT_STEPS];
   assign out_item.kind   = st_ff[SQRT_STEPS].kind;
   assign out_item.root   = st_ff[SQRT_STEPS].root;
   assign out_item.coef_a = st_ff[SQRT_STEPS].coef_a;
   assign out_item.coef_b = st_ff[SQRT_STEPS].coef_b;

endmodule : qrs_sqrt
`default_nettype wire

// ===== design/qrs_divide.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_divide
// Builds both numerators, then two restoring dividers by |2a| in lockstep,
// one quotient bit per stage, with sign fix and Q16.16 saturation.
// ----------------------------------------------------------------------------
module qrs_divide import qrs_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     enable,
   input  wire logic     in_valid,
   input  wire root_type in_item,
   output logic          out_valid,
   output rsp_type       out_item
);

   typedef struct packed {
      logic [QUO_W-1:0]  num;
      logic [DREM_W-1:0] rem;
      logic [QUO_W-1:0]  quo;
   } div_lane_type;

   typedef struct packed {
      root_kind_type    kind;
      logic [DEN_W-1:0] den;
      logic             neg1;
      logic             neg2;
      div_lane_type     l1;
      div_lane_type     l2;
   } div_state_type;

   div_state_type        st_ff [DIV_STEPS+1];
   div_state_type        st_in [DIV_STEPS+1];
   logic [DIV_STEPS:0]   vld_ff, vld_in;

   logic signed [NSUM_W-1:0] nb, sx, n1, n2;
   logic signed [DEN_W:0]    two_a;

   function automatic div_lane_type div_step(input div_lane_type s,
                                             input logic [DEN_W-1:0] den);
      logic [DREM_W-1:0] r;
      div_lane_type      o;
      r     = {s.rem[DREM_W-2:0], s.num[QUO_W-1]};
      o.num = {s.num[QUO_W-2:0], 1'b0};
      if (r >= {1'b0, den}) begin
         o.rem = r - {1'b0, den};
         o.quo = {s.quo[QUO_W-2:0], 1'b1};
      end else begin
         o.rem = r;
         o.quo = {s.quo[QUO_W-2:0], 1'b0};
      end
      return o;
   endfunction

   function automatic logic [OUT_W-1:0] saturate(input logic [QUO_W-1:0] q,
                                                 input logic neg);
      logic over;
      over = |q[QUO_W-1:OUT_W-1];
      if (neg) begin
         return over ? {1'b1, {(OUT_W-1){1'b0}}} : -q[OUT_W-1:0];
      end
      return over ? {1'b0, {(OUT_W-1){1'b1}}} : q[OUT_W-1:0];
   endfunction

   always_comb begin
      nb    = -NSUM_W'(in_item.coef_b);
      sx    = NSUM_W'({1'b0, in_item.root});
      two_a = (DEN_W+1)'(in_item.coef_a) <<< 1;
      unique case (in_item.kind)
         KIND_DISTINCT: begin n1 = nb + sx; n2 = nb - sx; end
         KIND_COMPLEX:  begin n1 = nb;      n2 = sx;      end
         default:       begin n1 = nb;      n2 = nb;      end
      endcase
      st_in[0].kind   = in_item.kind;
      st_in[0].den    = two_a[DEN_W] ? DEN_W'(-two_a) : DEN_W'(two_a);
      st_in[0].neg1   = n1[NSUM_W-1] != in_item.coef_a[COEF_W-1];
      st_in[0].neg2   = n2[NSUM_W-1] != in_item.coef_a[COEF_W-1];
      st_in[0].l1.num = {(n1[NSUM_W-1] ? NUM_W'(-n1) : NUM_W'(n1)), {OUT_FRAC{1'b0}}};
      st_in[0].l2.num = {(n2[NSUM_W-1] ? NUM_W'(-n2) : NUM_W'(n2)), {OUT_FRAC{1'b0}}};
      st_in[0].l1.rem = '0;
      st_in[0].l1.quo = '0;
      st_in[0].l2.rem = '0;
      st_in[0].l2.quo = '0;
      vld_in[0]       = in_valid;
      for (int k = 0; k < DIV_STEPS; k++) begin
         st_in[k+1]    = st_ff[k];
         st_in[k+1].l1 = div_step(st_ff[k].l1, st_ff[k].den);
         st_in[k+1].l2 = div_step(st_ff[k].l2, st_ff[k].den);
         vld_in[k+1]   = vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (enable) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) st_ff <= st_in;
   end

   always_comb begin
      out_valid          = vld_ff[DIV_STEPS];
      out_item.root_kind = st_ff[DIV_STEPS].kind;
      if (st_ff[DIV_STEPS].kind == KIND_A_ZERO) begin
         out_item.first_value  = '0;
         out_item.second_value = '0;
      end else begin
         out_item.first_value  = saturate(st_ff[DIV_STEPS].l1.quo, st_ff[DIV_STEPS].neg1);
         out_item.second_value = saturate(st_ff[DIV_STEPS].l2.quo, st_ff[DIV_STEPS].neg2);
      end
   end

endmodule : qrs_divide
`default_nettype wire

// ===== design/quadratic_root_solver_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_root_solver_top
// Fixed-point quadratic root solver: Q8.8 coefficients in, Q16.16 roots out.
// ----------------------------------------------------------------------------
// Takes one transaction of coefficients a, b, c per clock cycle while req_stall
// is low and returns one result transaction for each, in order. The
// discriminant b*b - 4ac is formed exactly and classifies the roots; distinct
// and equal roots are returned as two real values, complex roots as real part
// and imaginary part (the latter keeps the sign of a). a of zero returns kind 3
// with both values zero. Square root and division truncate toward zero and
// results saturate at the Q16.16 limits. Sustained rate is one transaction per
// cycle while rsp_stall stays low. From the accepting edge the products load,
// then the classify register, the queue (where an entry may wait), an input
// stage and 17 square root stages (one root bit each), 1 numerator stage and
// 33 division stages (one quotient bit each), plus the output register. The
// four-entry queue lets the front keep taking transactions while the back
// pipeline is held by rsp_stall.
// ----------------------------------------------------------------------------
module quadratic_root_solver_top import qrs_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_payload
);

   logic      front_en, back_en;
   logic      cls_valid;
   class_type cls_item, q_head;
   logic      q_empty, q_full;
   logic      root_valid;
   root_type  root_item;
   logic      div_valid;
   rsp_type   div_item;
   logic      rsp_valid_ff;
   rsp_type   rsp_ff;

   // the whole back pipeline moves whenever the output register can take a word
   assign back_en = !rsp_valid_ff || !rsp_stall;
   // the front moves while the queue has room, counting a pop this cycle
   assign front_en  = !q_full || (back_en && !q_empty);
   assign req_stall = !front_en;

   qrs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (front_en),
      .in_valid  (req_valid),
      .in_item   (req_payload),
      .out_valid (cls_valid),
      .out_item  (cls_item)
   );

   qrs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cls_valid && front_en),
      .push_item (cls_item),
      .pop       (back_en),
      .empty     (q_empty),
      .full      (q_full),
      .head      (q_head)
   );

   qrs_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (back_en),
      .in_valid  (!q_empty),
      .in_item   (q_head),
      .out_valid (root_valid),
      .out_item  (root_item)
   );

   qrs_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .enable    (back_en),
      .in_valid  (root_valid),
      .in_item   (root_item),
      .out_valid (div_valid),
      .out_item  (div_item)
   );

   // output register: holds the result while the consumer stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (back_en) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (back_en) rsp_ff <= div_item;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule : quadratic_root_solver_top
`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for quadratic_root_solver_top.
// ----------------------------------------------------------------------------
// Directed table of coefficient sets (extremes, every root kind, a of zero,
// saturation), then random sets. Each accepted transaction is run through a
// local root predictor and queued; each result transaction is compared field by
// field with the oldest queued root set. Idling runs in phases on both sides,
// with a long receiver hold-off and a sender pause until the pipe drains.
// ----------------------------------------------------------------------------
module testbench import qrs_pkg::*; ();

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 6;
   localparam int RANDOM_SETS  = 900;
   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 150;

   // sender/receiver idling phases
   typedef enum int {
      PHASE_NONE,
      PHASE_SEND_IDLE,
      PHASE_RECV_STALL,
      PHASE_BOTH
   } idle_phase_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   rsp_type        expected_roots[$];
   idle_phase_type idle_phase = PHASE_NONE;
   bit             hold_off = 1'b0;
   int             mismatch_count = 0;
   int             cycle_count = 0;

   // directed row: coefficients and, where obvious, the result
   typedef struct {
      req_type coefs;
      bit      known;
      rsp_type result;
   } directed_row_type;

   directed_row_type directed_rows[$];

   always #HALF_PERIOD clock = ~clock;

   quadratic_root_solver_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   // integer square root, truncated
   function automatic longint unsigned isqrt(longint unsigned x);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // (num * 2^16) / den toward zero, saturated to Q16.16
   function automatic logic signed [OUT_W-1:0] q16_divide(longint num, longint den);
      longint unsigned n_mag;
      longint unsigned d_mag;
      longint unsigned quo;
      bit              neg;
      neg = (num < 0) != (den < 0);
      n_mag = (num < 0) ? -num : num;
      d_mag = (den < 0) ? -den : den;
      quo = (n_mag << OUT_FRAC) / d_mag;
      if (neg) begin
         if (quo >= 64'h8000_0000) return 32'sh8000_0000;
         return -$signed(quo[OUT_W-1:0]);
      end
      if (quo > 64'h7FFF_FFFF) return 32'sh7FFF_FFFF;
      return quo[OUT_W-1:0];
   endfunction

   function automatic rsp_type solve_roots(req_type coefs);
      rsp_type res;
      longint  a;
      longint  b;
      longint  c;
      longint  disc;
      longint  root;
      a = coefs.coef_a;
      b = coefs.coef_b;
      c = coefs.coef_c;
      res = '0;
      if (a == 0) begin
         res.root_kind = KIND_A_ZERO;
         return res;
      end
      disc = b * b - 4 * (a * c);
      if (disc > 0) begin
         root = isqrt(disc);
         res.root_kind = KIND_DISTINCT;
         res.first_value = q16_divide(-b + root, 2 * a);
         res.second_value = q16_divide(-b - root, 2 * a);
      end else if (disc == 0) begin
         res.root_kind = KIND_EQUAL;
         res.first_value = q16_divide(-b, 2 * a);
         res.second_value = res.first_value;
      end else begin
         root = isqrt(-disc);
         res.root_kind = KIND_COMPLEX;
         res.first_value = q16_divide(-b, 2 * a);
         res.second_value = q16_divide(root, 2 * a);
      end
      return res;
   endfunction

   function automatic req_type coef_set(int a, int b, int c);
      req_type r;
      r.coef_a = a[COEF_W-1:0];
      r.coef_b = b[COEF_W-1:0];
      r.coef_c = c[COEF_W-1:0];
      return r;
   endfunction

   task automatic add_row(int a, int b, int c, bit known = 0,
                          root_kind_type kind = KIND_A_ZERO,
                          int first = 0, int second = 0);
      directed_row_type row;
      row.coefs = coef_set(a, b, c);
      row.known = known;
      row.result.root_kind = kind;
      row.result.first_value = first;
      row.result.second_value = second;
      directed_rows.push_back(row);
   endtask

   // random coefficient, biased toward extremes and small values
   function automatic int random_coef();
      case ($urandom_range(0, 9))
         0: return -32768;
         1: return 32767;
         2: return 0;
         3, 4: return $urandom_range(0, 1023) - 512;
         default: return $urandom_range(0, 65535) - 32768;
      endcase
   endfunction

   // offer one transaction and wait until it is taken; valid stays up
   // afterwards until the next offer, an idle cycle or a drain replaces it
   task automatic send_set(req_type coefs);
      bit idle;
      idle = 0;
      case (idle_phase)
         PHASE_SEND_IDLE, PHASE_BOTH: idle = 1;
         default: idle = 0;
      endcase
      while (idle && $urandom_range(0, 99) < 47) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= coefs;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_roots.push_back(solve_roots(coefs));
   endtask

   // receiver: random stall per phase, or a forced hold-off
   always @(posedge clock) begin
      if (hold_off)
         rsp_stall <= 1'b1;
      else if (idle_phase == PHASE_RECV_STALL)
         rsp_stall <= ($urandom_range(0, 99) < 47);
      else if (idle_phase == PHASE_BOTH)
         rsp_stall <= ($urandom_range(0, 99) < 6);
      else
         rsp_stall <= 1'b0;
   end

   // result checker: compare with the oldest expected root set
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_roots.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result transaction: %p", rsp_payload);
         end else begin
            want = expected_roots.pop_front();
            if (want.root_kind !== rsp_payload.root_kind
                || want.first_value !== rsp_payload.first_value
                || want.second_value !== rsp_payload.second_value) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result mismatch: expected %p, got %p", want, rsp_payload);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // the long hold-off counts its own cycles
   task automatic hold_receiver();
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_roots.size() != 0) @(posedge clock);
   endtask

   initial begin
      // a of zero: fixed zero result
      add_row(0, 0, 0, 1, KIND_A_ZERO, 0, 0);
      add_row(0, 32767, -32768, 1, KIND_A_ZERO, 0, 0);
      add_row(0, -32768, 32767, 1, KIND_A_ZERO, 0, 0);
      // x^2 = 0: equal roots at zero
      add_row(256, 0, 0, 1, KIND_EQUAL, 0, 0);
      // x^2 - 1: roots +1, -1
      add_row(256, 0, -256, 1, KIND_DISTINCT, 65536, -65536);
      // x^2 + 1: complex, imag 1
      add_row(256, 0, 256, 1, KIND_COMPLEX, 0, 65536);
      // -(x^2 + 1): imaginary part follows the sign of a
      add_row(-256, 0, -256, 1, KIND_COMPLEX, 0, -65536);
      // x^2 - 2x + 1: double root at 1
      add_row(256, -512, 256, 1, KIND_EQUAL, 65536, 65536);
      // tiny a with big b or c: large roots, some of them saturating
      add_row(1, 32767, 0);
      add_row(1, -32768, 0);
      add_row(-1, 32767, 0);
      add_row(-1, -32768, 32767);
      add_row(1, 0, -32768);
      add_row(1, 0, 32767);
      // extremes, then two moderate sets
      add_row(-32768, -32768, -32768);
      add_row(32767, 32767, 32767);
      add_row(-32768, 32767, 32767);
      add_row(32767, -32768, -32768);
      add_row(-32768, 0, 32767);
      add_row(32767, 0, -32768);
      add_row(-32768, -32768, 0);
      add_row(512, 1280, 768);
      add_row(-768, 100, 4000);

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, no idling
      foreach (directed_rows[i]) begin
         send_set(directed_rows[i].coefs);
         if (directed_rows[i].known)
            expected_roots[$] = directed_rows[i].result;
      end
      wait_drained();

      // random part through the idling phases
      for (int n = 0; n < RANDOM_SETS; n++) begin
         idle_phase = idle_phase_type'((n / 100) % 4);
         if (n == 450) begin
            // sender pauses until every result has come back
            wait_drained();
         end
         if (n == 600) begin
            // receiver holds off while the sender keeps offering
            fork
               hold_receiver();
            join_none
         end
         send_set(coef_set(random_coef(), random_coef(), random_coef()));
      end

      idle_phase = PHASE_NONE;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
